### hw/rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, register indexes and constants of the periodic task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  localparam int unsigned PERIOD_REGS   = 4;
  localparam int unsigned MASK_W        = 4;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned PERIOD_W      = 16;
  localparam int unsigned THR_W         = 17;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned COUNT_W       = 3;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 16;
  localparam int unsigned NUM_TASKS_DEF = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [COUNT_W-1:0]  ACTIVE_RESET = 3'd4;

  // ceil(2^19 / 3): exact reciprocal of 3 for operands below 2^18
  localparam logic [17:0] RECIP_THIRD = 18'd174763;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD_TASK_ZERO  = 3'd0,
    REG_PERIOD_TASK_ONE   = 3'd1,
    REG_PERIOD_TASK_TWO   = 3'd2,
    REG_PERIOD_TASK_THREE = 3'd3,
    REG_REALTIME_MASK     = 3'd4,
    REG_ACTIVE_TASKS      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic run;
    logic lag;
    logic trig;
  } lane_res_t;

  // floor(4 * period / 3) = (period * ceil(2^19/3)) >> 17
  function automatic logic [THR_W-1:0] catch_limit(input logic [PERIOD_W-1:0] period);
    logic [PERIOD_W+18-1:0] prod;
    prod = {18'd0, period} * {16'd0, RECIP_THIRD};
    return prod[PERIOD_W+18-1:17];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ptd_lane.sv
// ----------------------------------------------------------------------------
// ptd_lane
// One task slot: holds its start time and decides run, resync and signal use.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic                           enable,
  input  wire logic                           realtime_en,
  input  wire logic                           raised,
  input  wire logic [ptd_pkg::TIME_W-1:0]     now_ms,
  input  wire logic [ptd_pkg::PERIOD_W-1:0]   period,
  input  wire logic [ptd_pkg::THR_W-1:0]      limit,
  output ptd_pkg::lane_res_t                  res
);

  logic [ptd_pkg::TIME_W-1:0] last_start;
  logic [ptd_pkg::TIME_W-1:0] last_start_next;
  logic [ptd_pkg::TIME_W-1:0] elapsed;
  logic                       due;
  logic                       catch_up;

  always_comb begin
    elapsed  = now_ms - last_start;
    due      = enable &&
               ((elapsed >= {{(ptd_pkg::TIME_W-ptd_pkg::PERIOD_W){1'b0}}, period}) || raised);
    catch_up = realtime_en &&
               (elapsed < {{(ptd_pkg::TIME_W-ptd_pkg::THR_W){1'b0}}, limit});
    if (catch_up) begin
      last_start_next = last_start + {{(ptd_pkg::TIME_W-ptd_pkg::PERIOD_W){1'b0}}, period};
    end else begin
      last_start_next = now_ms;
    end
    res.run  = due;
    res.lag  = due && !catch_up;
    res.trig = due && raised;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_start <= '0;
    end else if (advance && due) begin
      last_start <= last_start_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/periodic_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_unit
// Cooperative periodic task dispatcher: one scheduler pass per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pass: the millisecond timestamp and the task signals.
//   m_axis returns exactly one result per pass: run, lagged and triggered
//   masks and an any-run flag. Tasks are evaluated side by side.
//   Each pass moves through the input register, then the result register,
//   before its result is offered on m_axis. Throughput: one pass per cycle
//   while m_axis_tready is high.
//   The start time of each running task is updated when its pass moves
//   from the input register into the result register, so back-to-back
//   passes see the state left by the previous one.
//   cfg_we/cfg_index/cfg_wdata write the period, realtime mask and active
//   count registers; the catch-up limit 4*period/3 is formed at write time.
//   Reset clears all start times to 0, sets periods to 100 ms, the realtime
//   mask to 0 and the active count to 4, and empties both registers.
//   When m_axis_tready is low the result holds and one more pass may wait
//   in the input register; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher_unit #(
  parameter int unsigned NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] now_ms, [35:32] signal_mask, [39:36] zero
  input  wire logic [ptd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] run_mask, [7:4] lagged_mask, [11:8] triggered_mask, [12] any_run, [15:13] zero
  output logic [ptd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [ptd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned LANES =
    (NUM_TASKS < ptd_pkg::PERIOD_REGS) ? NUM_TASKS : ptd_pkg::PERIOD_REGS;

  logic [ptd_pkg::PERIOD_W-1:0]   period [ptd_pkg::PERIOD_REGS];
  logic [ptd_pkg::THR_W-1:0]      limit  [ptd_pkg::PERIOD_REGS];
  logic [ptd_pkg::MASK_W-1:0]     realtime_mask;
  logic [ptd_pkg::COUNT_W-1:0]    active_tasks;

  logic                           in_valid;
  logic [ptd_pkg::TIME_W-1:0]     in_now;
  logic [ptd_pkg::MASK_W-1:0]     in_sig;
  logic                           out_valid;
  logic [ptd_pkg::OUT_TDATA_W-1:0] out_data;

  logic                           advance;
  logic [ptd_pkg::MASK_W-1:0]     run_mask;
  logic [ptd_pkg::MASK_W-1:0]     lagged_mask;
  logic [ptd_pkg::MASK_W-1:0]     triggered_mask;
  ptd_pkg::lane_res_t             lane_res [LANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptd_pkg::PERIOD_REGS; i++) begin
        period[i] <= ptd_pkg::PERIOD_RESET;
        limit[i]  <= ptd_pkg::catch_limit(ptd_pkg::PERIOD_RESET);
      end
      realtime_mask <= '0;
      active_tasks  <= ptd_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptd_pkg::REG_PERIOD_TASK_ZERO: begin
          period[0] <= cfg_wdata;
          limit[0]  <= ptd_pkg::catch_limit(cfg_wdata);
        end
        ptd_pkg::REG_PERIOD_TASK_ONE: begin
          period[1] <= cfg_wdata;
          limit[1]  <= ptd_pkg::catch_limit(cfg_wdata);
        end
        ptd_pkg::REG_PERIOD_TASK_TWO: begin
          period[2] <= cfg_wdata;
          limit[2]  <= ptd_pkg::catch_limit(cfg_wdata);
        end
        ptd_pkg::REG_PERIOD_TASK_THREE: begin
          period[3] <= cfg_wdata;
          limit[3]  <= ptd_pkg::catch_limit(cfg_wdata);
        end
        ptd_pkg::REG_REALTIME_MASK: begin
          realtime_mask <= cfg_wdata[ptd_pkg::MASK_W-1:0];
        end
        ptd_pkg::REG_ACTIVE_TASKS: begin
          active_tasks <= cfg_wdata[ptd_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_now <= s_axis_tdata[ptd_pkg::TIME_W-1:0];
      in_sig <= s_axis_tdata[ptd_pkg::TIME_W +: ptd_pkg::MASK_W];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ptd_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .enable      (active_tasks > ptd_pkg::COUNT_W'(g)),
      .realtime_en (realtime_mask[g]),
      .raised      (in_sig[g]),
      .now_ms      (in_now),
      .period      (period[g]),
      .limit       (limit[g]),
      .res         (lane_res[g])
    );
  end

  always_comb begin
    run_mask       = '0;
    lagged_mask    = '0;
    triggered_mask = '0;
    for (int i = 0; i < LANES; i++) begin
      run_mask[i]       = lane_res[i].run;
      lagged_mask[i]    = lane_res[i].lag;
      triggered_mask[i] = lane_res[i].trig;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {3'b000, |run_mask, triggered_mask, lagged_mask, run_mask};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTH
  a_any_run_matches : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[12] == (|m_axis_tdata[3:0])))
    else $error("any_run does not match run_mask");

  a_masks_within_run : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (((m_axis_tdata[7:4] & ~m_axis_tdata[3:0]) == 4'd0) &&
                       ((m_axis_tdata[11:8] & ~m_axis_tdata[3:0]) == 4'd0)))
    else $error("lagged or triggered task that did not run");

  a_advance_fills_result : assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("pass advanced but no result is held");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled with an empty input register");
`endif

endmodule

`default_nettype wire
